/* design/number_to_ascii_formatter_unit_macros.svh */
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_unit_macros.svh
// Assertion macros for the number to ASCII formatter.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH
`define NUMBER_TO_ASCII_FORMATTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define N2A_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define N2A_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define N2A_ASSERT(label, clk, rst_n, prop, msg)
`define N2A_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

/* design/n2a_pkg.sv */
// ----------------------------------------------------------------------------
// n2a_pkg
// Types, constants and the binary to BCD step for the number formatter.
// ----------------------------------------------------------------------------
package n2a_pkg;

    localparam int ValueWidth   = 32;
    localparam int DigitCount   = 10;
    localparam int DabbleStages = 4;
    localparam int BitsPerStage = ValueWidth / DabbleStages;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_HEX_ALPHA = 8'h37;
    localparam logic [7:0] ASCII_UPPER_E = 8'h45;
    localparam logic [7:0] ASCII_LOWER_R = 8'h72;

    typedef enum logic [2:0] {
        FUNC_BIN8  = 3'd0,
        FUNC_HEX2  = 3'd1,
        FUNC_DEC2  = 3'd2,
        FUNC_DEC3  = 3'd3,
        FUNC_DEC5  = 3'd4,
        FUNC_DEC10 = 3'd5
    } n2a_func_t;

    typedef struct packed {
        logic [2:0]              func;
        logic [ValueWidth-1:0]   value;
    } n2a_cmd_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } n2a_result_t;

    typedef struct packed {
        n2a_func_t                  func;
        logic                       err;
        logic [7:0]                 low_byte;
        logic [DigitCount-1:0][3:0] bcd;
        logic [ValueWidth-1:0]      bin;
    } n2a_work_t;

    function automatic n2a_work_t n2a_dabble(input n2a_work_t w);
        n2a_work_t r;
        r = w;
        for (int s = 0; s < BitsPerStage; s++) begin
            for (int d = 0; d < DigitCount; d++) begin
                if (r.bcd[d] >= 4'd5) begin
                    r.bcd[d] = r.bcd[d] + 4'd3;
                end
            end
            r.bcd = (DigitCount*4)'({r.bcd, r.bin[ValueWidth-1]});
            r.bin = {r.bin[ValueWidth-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* design/n2a_dabble_stage.sv */
// ----------------------------------------------------------------------------
// n2a_dabble_stage
// One pipeline stage of the binary to BCD conversion, eight bits per stage.
// ----------------------------------------------------------------------------
module n2a_dabble_stage
    import n2a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  n2a_work_t up_word,
    output logic      up_ready,
    output logic      dn_valid,
    output n2a_work_t dn_word,
    input  logic      dn_ready
);

    logic      valid_reg;
    logic      valid_next;
    n2a_work_t word_reg;
    n2a_work_t word_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
            if (up_valid)
            begin
                word_next = n2a_dabble(up_word);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

/* design/n2a_serializer.sv */
// ----------------------------------------------------------------------------
// n2a_serializer
// Turns one converted word into its characters, one per cycle.
// ----------------------------------------------------------------------------
`include "number_to_ascii_formatter_unit_macros.svh"

module n2a_serializer
    import n2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    input  n2a_work_t   up_word,
    output logic        up_ready,
    output n2a_result_t result,
    output logic        strobe
);

    logic        active_reg;
    logic        active_next;
    n2a_work_t   word_reg;
    n2a_work_t   word_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic [3:0]  end_reg;
    logic [3:0]  end_next;
    logic        strobe_reg;
    n2a_result_t result_reg;
    n2a_result_t result_next;

    logic        at_end;
    logic [3:0]  load_start;
    logic [3:0]  load_end;
    logic [3:0]  digit_idx;
    logic [3:0]  nibble;
    logic [7:0]  hex_char;
    logic [7:0]  char_code;

    assign at_end   = (cnt_reg == end_reg);
    assign up_ready = !active_reg || at_end;

    always_comb
    begin
        load_start = 4'd0;
        load_end   = 4'd0;
        if (up_word.err)
        begin
            load_end = 4'd2;
        end
        else
        begin
            unique case (up_word.func)
                FUNC_BIN8:  load_end = 4'd7;
                FUNC_HEX2:  load_end = 4'd1;
                FUNC_DEC2:
                begin
                    load_start = 4'd8;
                    load_end   = 4'd9;
                end
                FUNC_DEC3:
                begin
                    load_start = 4'd7;
                    load_end   = 4'd9;
                end
                FUNC_DEC5:
                begin
                    load_start = 4'd5;
                    load_end   = 4'd9;
                end
                FUNC_DEC10: load_end = 4'd9;
                default:    load_end = 4'd0;
            endcase
        end
    end

    assign digit_idx = 4'(DigitCount - 1) - cnt_reg;
    assign nibble    = (cnt_reg == 4'd0) ? word_reg.low_byte[7:4] : word_reg.low_byte[3:0];
    assign hex_char  = ({4'd0, nibble} > 8'd9) ? ({4'd0, nibble} + ASCII_HEX_ALPHA)
                                               : ({4'd0, nibble} + ASCII_ZERO);

    always_comb
    begin
        char_code = ASCII_ZERO;
        if (word_reg.err)
        begin
            char_code = (cnt_reg == 4'd0) ? ASCII_UPPER_E : ASCII_LOWER_R;
        end
        else
        begin
            unique case (word_reg.func) inside
                FUNC_BIN8:
                    char_code = ASCII_ZERO
                              | 8'(word_reg.low_byte[3'(3'd7 - cnt_reg[2:0])]);
                FUNC_HEX2:
                    char_code = hex_char;
                FUNC_DEC2, FUNC_DEC3, FUNC_DEC5, FUNC_DEC10:
                    char_code = ASCII_ZERO | {4'd0, word_reg.bcd[digit_idx]};
                default:
                    char_code = ASCII_ZERO;
            endcase
        end
    end

    always_comb
    begin
        active_next = active_reg;
        word_next   = word_reg;
        cnt_next    = cnt_reg;
        end_next    = end_reg;
        if (up_ready)
        begin
            active_next = up_valid;
            if (up_valid)
            begin
                word_next = up_word;
                cnt_next  = load_start;
                end_next  = load_end;
            end
        end
        else
        begin
            cnt_next = cnt_reg + 4'd1;
        end
        result_next.char_code = char_code;
        result_next.last      = at_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
            cnt_reg    <= 4'd0;
            end_reg    <= 4'd0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= active_reg;
            cnt_reg    <= cnt_next;
            end_reg    <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

    `N2A_ASSERT(a_cnt_in_range, clk, rst_n, active_reg |-> (cnt_reg <= end_reg), "counter past end")
    `N2A_ASSERT(a_strobe_from_active, clk, rst_n, strobe_reg |-> $past(active_reg), "stray strobe")
    `N2A_ASSERT(a_err_three_chars, clk, rst_n, (active_reg && word_reg.err) |-> (end_reg == 4'd2), "bad error length")

endmodule

/* design/number_to_ascii_formatter_unit.sv */
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_unit
// Formats a number as binary, hex or decimal ASCII, one character per word.
// ----------------------------------------------------------------------------
// A command word (cmd.func, cmd.value) is taken at a rising edge where start
// is high and busy is low. Each character of the text leaves as one result
// word on result, marked by strobe for exactly one cycle; result.last is set
// on the final character of the number. Modes 6 and 7 are taken and give no
// characters. Two-digit and three-digit decimal modes give "Err" on overflow.
// The first character passes the input register, four binary to BCD stages,
// the serializer and the output register. Throughput: one character per
// cycle; a number has 2 to 10 characters, and commands are taken back to
// back while the conversion stages have room, up to six in flight.
// busy rises only when every stage ahead of the serializer holds a word.
// Reset clears all valid bits; words in flight are dropped. The receiver
// cannot stall: every strobed word must be taken in its cycle.
// ----------------------------------------------------------------------------
`include "number_to_ascii_formatter_unit_macros.svh"

module number_to_ascii_formatter_unit
    import n2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  n2a_cmd_t    cmd,
    output n2a_result_t result,
    output logic        strobe
);

    logic      in_valid_reg;
    logic      in_valid_next;
    n2a_work_t in_word_reg;
    n2a_work_t in_word_next;
    logic      in_ready;
    logic      accept;
    logic      func_ok;

    logic      stg_valid [DabbleStages+1];
    n2a_work_t stg_word  [DabbleStages+1];
    logic      stg_ready [DabbleStages+1];

    assign in_ready = !in_valid_reg || stg_ready[0];
    assign busy     = !in_ready;
    assign accept   = start && in_ready;
    assign func_ok  = (cmd.func <= 3'(FUNC_DEC10));

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_word_next  = in_word_reg;
        if (in_ready)
        begin
            in_valid_next = accept && func_ok;
        end
        if (accept)
        begin
            in_word_next.func     = n2a_func_t'(cmd.func);
            in_word_next.low_byte = cmd.value[7:0];
            in_word_next.bcd      = '0;
            in_word_next.bin      = (cmd.func == 3'(FUNC_DEC5))
                                  ? {16'd0, cmd.value[15:0]} : cmd.value;
            in_word_next.err      = ((cmd.func == 3'(FUNC_DEC2)) && (cmd.value >= 32'd100))
                                 || ((cmd.func == 3'(FUNC_DEC3)) && (cmd.value >= 32'd1000));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_word_reg <= in_word_next;
    end

    assign stg_valid[0] = in_valid_reg;
    assign stg_word[0]  = in_word_reg;

    for (genvar g = 0; g < DabbleStages; g++)
    begin : g_dabble
        n2a_dabble_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[g]),
            .up_word  (stg_word[g]),
            .up_ready (stg_ready[g]),
            .dn_valid (stg_valid[g+1]),
            .dn_word  (stg_word[g+1]),
            .dn_ready (stg_ready[g+1])
        );
    end

    n2a_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stg_valid[DabbleStages]),
        .up_word  (stg_word[DabbleStages]),
        .up_ready (stg_ready[DabbleStages]),
        .result   (result),
        .strobe   (strobe)
    );

    `N2A_ASSERT(a_busy_held, clk, rst_n, busy |-> in_valid_reg, "busy without a held word")
    `N2A_ASSERT(a_bad_func_dropped, clk, rst_n, (accept && !func_ok) |=> !in_valid_reg, "unused mode entered pipeline")

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the number to ASCII formatter against an in-bench text predictor.
// A directed set covers every mode, both overflow limits, the narrow-mode
// masking and the unused modes. About 285 random commands follow. The sender
// throttle runs in three phases (29%, 60%, none) and holds off at times until
// every expected character word has come back.
// ----------------------------------------------------------------------------
module testbench;
    import n2a_pkg::*;

    localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
    localparam int         RandomNumbers  = 270;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    n2a_cmd_t    cmd = '0;
    n2a_result_t result;
    logic        strobe;

    n2a_cmd_t    number_q[$];
    bit          drain_q[$];
    n2a_result_t char_q[$];
    int          taken_count = 0;
    int          fail_count = 0;

    number_to_ascii_formatter_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .result (result),
        .strobe (strobe)
    );

    always #1 clk = ~clk;

    function automatic void add_number(logic [2:0] func, logic [31:0] value, bit drain);
        n2a_cmd_t c;
        c.func  = func;
        c.value = value;
        number_q.push_back(c);
        drain_q.push_back(drain);
    endfunction

    function automatic void push_char(logic [7:0] ch, logic fin);
        n2a_result_t r;
        r.char_code = ch;
        r.last      = fin;
        char_q.push_back(r);
    endfunction

    function automatic void push_err();
        push_char(ASCII_UPPER_E, 1'b0);
        push_char(ASCII_LOWER_R, 1'b0);
        push_char(ASCII_LOWER_R, 1'b1);
    endfunction

    function automatic void push_decimal(logic [31:0] x, int ndig);
        logic [3:0] digs [10];
        for (int i = 0; i < ndig; i++)
        begin
            digs[i] = 4'(x % 10);
            x = x / 10;
        end
        for (int i = ndig - 1; i >= 0; i--)
        begin
            push_char(ASCII_ZERO + 8'(digs[i]), i == 0);
        end
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return ASCII_ZERO + 8'(nib);
        end
        return ASCII_HEX_ALPHA + 8'(nib);
    endfunction

    function automatic void predict_text(n2a_cmd_t c);
        case (c.func)
            FUNC_BIN8:
            begin
                for (int i = 7; i >= 0; i--)
                begin
                    push_char(ASCII_ZERO + 8'(c.value[i]), i == 0);
                end
            end
            FUNC_HEX2:
            begin
                push_char(hex_char(c.value[7:4]), 1'b0);
                push_char(hex_char(c.value[3:0]), 1'b1);
            end
            FUNC_DEC2:
            begin
                if (c.value >= 100) push_err();
                else push_decimal(c.value, 2);
            end
            FUNC_DEC3:
            begin
                if (c.value >= 1000) push_err();
                else push_decimal(c.value, 3);
            end
            FUNC_DEC5:  push_decimal({16'h0, c.value[15:0]}, 5);
            FUNC_DEC10: push_decimal(c.value, 10);
            default:
            begin
            end
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        int  idle_pct;
        bit  accepted;
        bit  may_send;
        idle_pct = (taken_count < 110) ? 29 : (taken_count < 220) ? 60 : 0;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            accepted = start && !busy;
            if (accepted)
            begin
                predict_text(cmd);
                void'(number_q.pop_front());
                void'(drain_q.pop_front());
                taken_count++;
            end
            if (accepted || !start)
            begin
                may_send = number_q.size() != 0
                           && !(drain_q[0] && char_q.size() != 0)
                           && ($urandom_range(99) >= idle_pct);
                if (may_send)
                begin
                    start <= 1'b1;
                    cmd   <= number_q[0];
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        n2a_result_t want;
        if (rst_n && strobe)
        begin
            if (char_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word: char_code=%h last=%b",
                             result.char_code, result.last);
            end
            else
            begin
                want = char_q.pop_front();
                if (result.char_code !== want.char_code || result.last !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: char_code exp %h got %h, last exp %b got %b",
                                 want.char_code, result.char_code, want.last, result.last);
                end
            end
        end
    end

    initial
    begin
        int          counted;
        logic [2:0]  func;
        logic [31:0] value;

        add_number(FUNC_BIN8,  32'h0000_0000, 1'b0);
        add_number(FUNC_BIN8,  32'hFFFF_FFFF, 1'b0);
        add_number(FUNC_BIN8,  32'h1234_56A5, 1'b0);
        add_number(FUNC_HEX2,  32'h0000_0000, 1'b0);
        add_number(FUNC_HEX2,  32'hFFFF_FFFF, 1'b0);
        add_number(FUNC_HEX2,  32'h8765_439A, 1'b0);
        add_number(FUNC_DEC2,  32'd0,         1'b0);
        add_number(FUNC_DEC2,  32'd99,        1'b0);
        add_number(FUNC_DEC2,  32'd100,       1'b0);
        add_number(FUNC_DEC2,  32'h0100_0005, 1'b0);
        add_number(FUNC_DEC2,  32'hFFFF_FFFF, 1'b0);
        add_number(FUNC_DEC3,  32'd0,         1'b0);
        add_number(FUNC_DEC3,  32'd999,       1'b0);
        add_number(FUNC_DEC3,  32'd1000,      1'b0);
        add_number(FUNC_DEC5,  32'd0,         1'b0);
        add_number(FUNC_DEC5,  32'h0000_FFFF, 1'b0);
        add_number(FUNC_DEC5,  32'hFFFF_0007, 1'b0);
        add_number(FUNC_DEC10, 32'd0,         1'b0);
        add_number(FUNC_DEC10, 32'd999999999, 1'b0);
        add_number(FUNC_DEC10, 32'd1000000000, 1'b0);
        add_number(FUNC_DEC10, 32'hFFFF_FFFF, 1'b0);
        add_number(FUNC_UNUSED_LO, $urandom, 1'b0);
        add_number(FUNC_UNUSED_HI, $urandom, 1'b0);
        add_number(FUNC_DEC3,  32'd407,       1'b1);

        counted = 0;
        while (counted < RandomNumbers)
        begin
            if ($urandom_range(99) < 5)
                func = $urandom_range(1) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;
            else
                func = 3'($urandom_range(FUNC_DEC10));
            case ($urandom_range(3))
                0: value = $urandom;
                1: value = $urandom_range(1100);
                2: value = $urandom_range(120);
                default: value = $urandom >> $urandom_range(31);
            endcase
            add_number(func, value, (counted % 50) == 49);
            if (func < FUNC_UNUSED_LO)
                counted++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (number_q.size() != 0 || start || char_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (fail_count == 0)
            $display("number_to_ascii_formatter_unit test passed");
        else
            $display("number_to_ascii_formatter_unit test failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("number_to_ascii_formatter_unit test failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/n2a_pkg.sv
design/n2a_dabble_stage.sv
design/n2a_serializer.sv
design/number_to_ascii_formatter_unit.sv
tb/testbench.sv
